[src/onewire_rom_search_defines.svh]
// Assertion macros for the 1-Wire ROM search block.
// Expects clk and rst in the scope where a macro is used.
`ifndef ONEWIRE_ROM_SEARCH_DEFINES_SVH
`define ONEWIRE_ROM_SEARCH_DEFINES_SVH

// Checked on every clock edge out of reset.
`define ORS_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ROM search assertion failed");

// Checked on every clock edge, reset included.
`define ORS_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("ROM search assertion failed");

`endif

[src/ors_pkg.sv]
// Shared types and constants for the 1-Wire ROM search block.
// No dependencies.
package ors_pkg;

  localparam int FAM_W        = 4;
  localparam int FAMILY_LIMIT = 9;
  localparam int BYTE_W       = 8;

  typedef enum logic [1:0] {
    REQ_BEGIN_NEXT  = 2'd0,
    REQ_BEGIN_FIRST = 2'd1,
    REQ_TRIPLET     = 2'd2
  } req_code_t;

  typedef enum logic [1:0] {
    KIND_TRIPLET = 2'd0,
    KIND_FOUND   = 2'd1,
    KIND_NONE    = 2'd2,
    KIND_IGNORED = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       presence;
    logic       id_bit;
    logic       cmp_bit;
    logic       taken_dir;
  } ors_req_t;

  typedef struct packed {
    kind_t            kind;
    logic             direction;
    logic [FAM_W-1:0] family_discrepancy;
    logic             last_device;
  } ors_res_t;

endpackage

[src/ors_in_reg.sv]
// Input register: holds one accepted request until the engine takes it.
// Depends on ors_pkg.
module ors_in_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  ors_pkg::ors_req_t req_in,
  input  logic             advance,
  output logic             hold_valid,
  output ors_pkg::ors_req_t req_out
);
  import ors_pkg::*;

  assign req_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_ready) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_out <= req_in;
    end
  end

endmodule

[src/ors_engine.sv]
// Search state and the one-bit decision for each request.
// Depends on ors_pkg.
module ors_engine #(
  parameter int CODE_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  ors_pkg::ors_req_t    req,
  output ors_pkg::ors_res_t    res,
  output logic [CODE_BITS-1:0] res_code
);
  import ors_pkg::*;

  localparam int POS_W = $clog2(CODE_BITS + 1);
  localparam int IDX_W = $clog2(CODE_BITS);

  logic [CODE_BITS-1:0] code_store, code_store_next;
  logic [POS_W-1:0]     last_discrepancy, last_discrepancy_next;
  logic [FAM_W-1:0]     family_mark, family_mark_next;
  logic                 done_flag, done_flag_next;
  logic [POS_W-1:0]     bit_position, bit_position_next;
  logic [POS_W-1:0]     zero_pos, zero_pos_next;
  logic                 searching, searching_next;

  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] pos_dec;
  logic [POS_W-1:0] ld_begin;
  logic             done_begin;
  logic [POS_W-1:0] lz_new;
  logic [FAM_W-1:0] fam_new;
  logic             last_bit;

  function automatic logic dir_of(input logic [POS_W-1:0] p, input logic [POS_W-1:0] ld,
                                  input logic [CODE_BITS-1:0] code);
    logic [POS_W-1:0] pm1;
    pm1 = p - POS_W'(1);
    if (p < ld) return code[pm1[IDX_W-1:0]];
    return p == ld;
  endfunction

  assign pos_inc  = bit_position + POS_W'(1);
  assign pos_dec  = bit_position - POS_W'(1);
  assign last_bit = bit_position == POS_W'(CODE_BITS);
  assign ld_begin = (req.req_type == REQ_BEGIN_FIRST) ? '0 : last_discrepancy;
  assign done_begin = (req.req_type == REQ_BEGIN_FIRST) ? 1'b0 : done_flag;

  always_comb begin
    code_store_next       = code_store;
    last_discrepancy_next = last_discrepancy;
    family_mark_next      = family_mark;
    done_flag_next        = done_flag;
    bit_position_next     = bit_position;
    zero_pos_next         = zero_pos;
    searching_next        = searching;
    res                   = '{kind: KIND_IGNORED, direction: 1'b0,
                              family_discrepancy: '0, last_device: 1'b0};
    res_code              = '0;
    lz_new                = zero_pos;
    fam_new               = family_mark;

    unique case (req.req_type) inside
      REQ_BEGIN_NEXT, REQ_BEGIN_FIRST: begin
        searching_next    = 1'b0;
        bit_position_next = POS_W'(1);
        zero_pos_next     = '0;
        if (done_begin || !req.presence) begin
          last_discrepancy_next = '0;
          family_mark_next      = '0;
          done_flag_next        = 1'b0;
          res.kind              = KIND_NONE;
        end else begin
          searching_next        = 1'b1;
          last_discrepancy_next = ld_begin;
          family_mark_next      = (req.req_type == REQ_BEGIN_FIRST) ? '0 : family_mark;
          done_flag_next        = 1'b0;
          res.kind              = KIND_TRIPLET;
          res.direction         = dir_of(POS_W'(1), ld_begin, code_store);
        end
      end
      REQ_TRIPLET: begin
        if (searching) begin
          if (req.id_bit && req.cmp_bit) begin
            searching_next        = 1'b0;
            bit_position_next     = POS_W'(1);
            last_discrepancy_next = '0;
            family_mark_next      = '0;
            done_flag_next        = 1'b0;
            res.kind              = KIND_NONE;
          end else begin
            if (!req.id_bit && !req.cmp_bit && !req.taken_dir) begin
              lz_new = bit_position;
              if (bit_position < POS_W'(FAMILY_LIMIT)) fam_new = bit_position[FAM_W-1:0];
            end
            zero_pos_next    = lz_new;
            family_mark_next = fam_new;
            code_store_next[pos_dec[IDX_W-1:0]] = req.taken_dir;
            if (last_bit) begin
              searching_next        = 1'b0;
              bit_position_next     = POS_W'(1);
              last_discrepancy_next = lz_new;
              done_flag_next        = lz_new == '0;
              if (code_store_next[BYTE_W-1:0] == '0) begin
                last_discrepancy_next = '0;
                family_mark_next      = '0;
                done_flag_next        = 1'b0;
                res.kind              = KIND_NONE;
              end else begin
                res.kind               = KIND_FOUND;
                res.family_discrepancy = fam_new;
                res.last_device        = lz_new == '0;
                res_code               = code_store_next;
              end
            end else begin
              bit_position_next = pos_inc;
              res.kind          = KIND_TRIPLET;
              res.direction     = dir_of(pos_inc, last_discrepancy, code_store);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_store       <= '0;
      last_discrepancy <= '0;
      family_mark      <= '0;
      done_flag        <= 1'b0;
      bit_position     <= POS_W'(1);
      zero_pos         <= '0;
      searching        <= 1'b0;
    end else if (fire) begin
      code_store       <= code_store_next;
      last_discrepancy <= last_discrepancy_next;
      family_mark      <= family_mark_next;
      done_flag        <= done_flag_next;
      bit_position     <= bit_position_next;
      zero_pos         <= zero_pos_next;
      searching        <= searching_next;
    end
  end

endmodule

[src/ors_out_reg.sv]
// Result register: holds one result until the receiver takes it.
// Depends on ors_pkg.
module ors_out_reg #(
  parameter int CODE_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  ors_pkg::ors_res_t    res_in,
  input  logic [CODE_BITS-1:0] code_in,
  output logic                 free,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output ors_pkg::ors_res_t    res_out,
  output logic [CODE_BITS-1:0] code_out
);
  import ors_pkg::*;

  assign free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (free) begin
      rsp_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out  <= res_in;
      code_out <= code_in;
    end
  end

endmodule

[src/onewire_rom_search.sv]
// 1-Wire ROM search engine, top level.
// Depends on ors_pkg, ors_in_reg, ors_engine, ors_out_reg and the defines header.
//
// Use: the host drives the bus. It sends a begin request (first or next search,
// with the presence bit of its bus reset); the block answers with a triplet
// request and the direction to write. The host runs the triplet and sends
// back the two read bits and the direction taken. After CODE_BITS triplets the
// block answers with the found code, the family discrepancy and the
// last-device flag, or with "none found". Every request gets exactly one
// response, in order.
// Channels: req_* in, rsp_* out, valid/ready on both.
// Path: the input register holds the accepted request, the response register the result.
// Throughput: one request per cycle while the receiver takes responses; the
// decision is one bit of logic between the input register and the response register.
// A stalled receiver holds the response; one more request waits in the
// input register, after which req_ready drops.
// Reset: the search state clears, no search is running, both registers empty.
`include "onewire_rom_search_defines.svh"

module onewire_rom_search #(
  parameter int CODE_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic [1:0]           req_type,
  input  logic                 presence,
  input  logic                 id_bit,
  input  logic                 cmp_bit,
  input  logic                 taken_dir,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output logic [1:0]           kind,
  output logic                 direction,
  output logic [CODE_BITS-1:0] rom_code,
  output logic [3:0]           family_discrepancy,
  output logic                 last_device
);
  import ors_pkg::*;

  ors_req_t             req_in;
  ors_req_t             req_held;
  logic                 hold_valid;
  logic                 free;
  logic                 fire;
  ors_res_t             res_next;
  ors_res_t             res_q;
  logic [CODE_BITS-1:0] code_next;

  assign req_in = '{req_type: req_type, presence: presence, id_bit: id_bit,
                    cmp_bit: cmp_bit, taken_dir: taken_dir};
  assign fire   = hold_valid && free;

  ors_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_in     (req_in),
    .advance    (free),
    .hold_valid (hold_valid),
    .req_out    (req_held)
  );

  ors_engine #(.CODE_BITS(CODE_BITS)) u_engine (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .req      (req_held),
    .res      (res_next),
    .res_code (code_next)
  );

  ors_out_reg #(.CODE_BITS(CODE_BITS)) u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res_in    (res_next),
    .code_in   (code_next),
    .free      (free),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .res_out   (res_q),
    .code_out  (rom_code)
  );

  assign kind               = res_q.kind;
  assign direction          = res_q.direction;
  assign family_discrepancy = res_q.family_discrepancy;
  assign last_device        = res_q.last_device;

  `ORS_ASSERT(a_ready_when_empty, !rsp_valid |-> req_ready)
  `ORS_ASSERT(a_dir_only_triplet, (rsp_valid && kind != KIND_TRIPLET) |-> !direction)
  `ORS_ASSERT(a_found_fields, (rsp_valid && kind != KIND_FOUND) |-> (rom_code == '0 && family_discrepancy == '0 && !last_device))
  `ORS_ASSERT(a_family_range, rsp_valid |-> family_discrepancy < 4'(FAMILY_LIMIT))
  `ORS_ASSERT_ALWAYS(a_reset_empty, rst |=> (!rsp_valid && req_ready))

endmodule

[sim/onewire_rom_search_test.sv]
// Testbench for onewire_rom_search: walks random 1-Wire buses through the ROM search
// and checks every response against an in-bench search predictor.
// Depends on ors_pkg and the onewire_rom_search RTL.
module onewire_rom_search_test;
  import ors_pkg::*;

  localparam int CODE_BITS = 64;
  localparam int ITEMS = 1260;
  localparam int QUIET_LIMIT = 1000;
  localparam int DRAIN = 8;
  localparam int HOLD_CYCLES = 120;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic [6:0]           last_disc;
    logic [3:0]           family;
    logic                 done;
    logic [6:0]           bitpos;
    logic [6:0]           zero_pos;
    logic                 searching;
  } search_state_t;

  typedef struct packed {
    kind_t                kind;
    logic                 direction;
    logic [CODE_BITS-1:0] rom_code;
    logic [3:0]           family;
    logic                 last;
  } search_rsp_t;

  typedef struct packed {
    ors_req_t   rq;
    logic [2:0] gap;
  } pending_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  logic [1:0] req_type = '0;
  logic presence = 1'b0;
  logic id_bit = 1'b0;
  logic cmp_bit = 1'b0;
  logic taken_dir = 1'b0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  logic [1:0] kind;
  logic direction;
  logic [CODE_BITS-1:0] rom_code;
  logic [3:0] family_discrepancy;
  logic last_device;

  pending_req_t pending_reqs[$];
  search_rsp_t  expected_rsps[$];
  search_state_t gen_state;
  search_state_t track_state;
  pending_req_t next_req;
  search_rsp_t  want;
  search_rsp_t  predicted;
  int gap_max = 4;
  int gap_left = 0;
  int stall_left = 0;
  int stall_draw;
  int rsp_total = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  logic req_fire = 1'b0;
  logic rsp_fire = 1'b0;
  logic hold_off = 1'b0;

  onewire_rom_search #(.CODE_BITS(CODE_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_type(req_type),
    .presence(presence),
    .id_bit(id_bit),
    .cmp_bit(cmp_bit),
    .taken_dir(taken_dir),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .kind(kind),
    .direction(direction),
    .rom_code(rom_code),
    .family_discrepancy(family_discrepancy),
    .last_device(last_device)
  );

  function automatic void clear_marks(inout search_state_t st);
    st.last_disc = '0;
    st.family = '0;
    st.done = 1'b0;
  endfunction

  function automatic logic pick_direction(search_state_t st);
    if (st.bitpos < st.last_disc) begin
      return st.code[st.bitpos - 7'd1];
    end
    return st.bitpos == st.last_disc;
  endfunction

  function automatic void search_step(inout search_state_t st, input ors_req_t rq,
                                      output search_rsp_t r);
    r = '0;
    r.kind = KIND_IGNORED;
    if (rq.req_type == REQ_BEGIN_NEXT || rq.req_type == REQ_BEGIN_FIRST) begin
      if (rq.req_type == REQ_BEGIN_FIRST) clear_marks(st);
      st.searching = 1'b0;
      st.bitpos = 7'd1;
      st.zero_pos = '0;
      if (st.done || !rq.presence) begin
        clear_marks(st);
        r.kind = KIND_NONE;
      end else begin
        st.searching = 1'b1;
        r.kind = KIND_TRIPLET;
        r.direction = pick_direction(st);
      end
    end else if (rq.req_type == REQ_TRIPLET && st.searching) begin
      if (rq.id_bit && rq.cmp_bit) begin
        st.searching = 1'b0;
        st.bitpos = 7'd1;
        clear_marks(st);
        r.kind = KIND_NONE;
      end else begin
        if (!rq.id_bit && !rq.cmp_bit && !rq.taken_dir) begin
          st.zero_pos = st.bitpos;
          if (st.zero_pos < FAMILY_LIMIT) st.family = st.zero_pos[3:0];
        end
        st.code[st.bitpos - 7'd1] = rq.taken_dir;
        st.bitpos = st.bitpos + 7'd1;
        if (st.bitpos > CODE_BITS) begin
          st.searching = 1'b0;
          st.bitpos = 7'd1;
          st.last_disc = st.zero_pos;
          st.done = (st.last_disc == 0);
          if (st.code[7:0] == 8'd0) begin
            clear_marks(st);
            r.kind = KIND_NONE;
          end else begin
            r.kind = KIND_FOUND;
            r.rom_code = st.code;
            r.family = st.family;
            r.last = st.done;
          end
        end else begin
          r.kind = KIND_TRIPLET;
          r.direction = pick_direction(st);
        end
      end
    end
  endfunction

  // queue one request and advance the generator's copy of the search state
  function automatic search_rsp_t offer(logic [1:0] rtype, logic pres, logic idb,
                                        logic cmpb, logic tk);
    ors_req_t rq;
    pending_req_t item;
    search_rsp_t r;
    rq.req_type = rtype;
    rq.presence = pres;
    rq.id_bit = idb;
    rq.cmp_bit = cmpb;
    rq.taken_dir = tk;
    search_step(gen_state, rq, r);
    item.rq = rq;
    item.gap = 3'($urandom_range(0, gap_max));
    pending_reqs.push_back(item);
    return r;
  endfunction

  // enumerate a random bus of devices that share code prefixes
  task automatic walk_bus(input int ndev, input bit zero_low);
    logic [CODE_BITS-1:0] devs [4];
    logic [CODE_BITS-1:0] keep;
    logic [3:0] alive;
    search_rsp_t r;
    int pos;
    int at;
    int i;
    int s;
    logic idb;
    logic cmpb;
    logic tk;
    devs[0] = {$urandom, $urandom};
    if ($urandom_range(0, 15) == 0) devs[0] = '1;
    if (zero_low) devs[0][7:0] = '0;
    for (i = 1; i < ndev; i++) begin
      pos = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(8, CODE_BITS - 1);
      keep = '1;
      keep = keep >> (CODE_BITS - 1 - pos);
      devs[i] = devs[0];
      devs[i][pos] = ~devs[0][pos];
      devs[i] = (devs[i] & keep) | ({$urandom, $urandom} & ~keep);
    end
    for (s = 0; s <= ndev; s++) begin
      r = offer(s == 0 ? REQ_BEGIN_FIRST : REQ_BEGIN_NEXT, $urandom_range(0, 39) != 0,
                $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
      alive = '0;
      for (i = 0; i < ndev; i++) alive[i] = 1'b1;
      while (r.kind == KIND_TRIPLET) begin
        at = gen_state.bitpos - 1;
        idb = 1'b1;
        cmpb = 1'b1;
        for (i = 0; i < ndev; i++) begin
          if (alive[i]) begin
            if (devs[i][at]) cmpb = 1'b0;
            else idb = 1'b0;
          end
        end
        if (idb != cmpb) tk = idb;
        else if (!idb) tk = r.direction;
        else tk = $urandom_range(0, 1);
        // occasional corrupted read
        if ($urandom_range(0, 299) == 0) idb = ~idb;
        if ($urandom_range(0, 299) == 0) cmpb = ~cmpb;
        r = offer(REQ_TRIPLET, $urandom_range(0, 1), idb, cmpb, tk);
        for (i = 0; i < ndev; i++) begin
          if (devs[i][at] != tk) alive[i] = 1'b0;
        end
      end
      if (r.kind != KIND_FOUND) break;
    end
  endtask

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    gen_state = '0;
    gen_state.bitpos = 7'd1;
    track_state = gen_state;

    void'(offer(REQ_TRIPLET, 1'b1, 1'b1, 1'b1, 1'b1));
    void'(offer(REQ_UNKNOWN, 1'b1, 1'b1, 1'b1, 1'b1));
    void'(offer(REQ_BEGIN_NEXT, 1'b0, 1'b0, 1'b0, 1'b0));
    void'(offer(REQ_BEGIN_FIRST, 1'b0, 1'b1, 1'b0, 1'b1));
    void'(offer(REQ_BEGIN_FIRST, 1'b1, 1'b0, 1'b0, 1'b0));
    void'(offer(REQ_TRIPLET, 1'b0, 1'b0, 1'b0, 1'b0));
    void'(offer(REQ_TRIPLET, 1'b1, 1'b1, 1'b0, 1'b1));
    void'(offer(REQ_TRIPLET, 1'b0, 1'b0, 1'b1, 1'b0));
    void'(offer(REQ_BEGIN_NEXT, 1'b1, 1'b1, 1'b1, 1'b1));
    void'(offer(REQ_TRIPLET, 1'b1, 1'b0, 1'b0, 1'b1));
    void'(offer(REQ_TRIPLET, 1'b0, 1'b1, 1'b1, 1'b0));
    void'(offer(REQ_TRIPLET, 1'b0, 1'b0, 1'b1, 1'b1));
    void'(offer(REQ_UNKNOWN, 1'b0, 1'b0, 1'b0, 1'b0));

    while (pending_reqs.size() < ITEMS) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
      if ($urandom_range(0, 9) < 8) begin
        walk_bus($urandom_range(1, 4), $urandom_range(0, 9) == 0);
      end else begin
        repeat ($urandom_range(1, 10)) begin
          void'(offer($urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 1),
                      $urandom_range(0, 1), $urandom_range(0, 1)));
        end
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN) @(negedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("onewire_rom_search: match");
    end else begin
      $display("onewire_rom_search: mismatch");
    end
    $finish;
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      gap_left <= 0;
    end else if (!req_valid || req_fire) begin
      if (gap_left != 0) begin
        req_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() != 0) begin
        next_req = pending_reqs.pop_front();
        {req_type, presence, id_bit, cmp_bit, taken_dir} <= next_req.rq;
        req_valid <= 1'b1;
        gap_left <= next_req.gap;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // response receiver
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      stall_left <= 0;
    end else if (hold_off) begin
      rsp_ready <= 1'b0;
    end else if (rsp_fire) begin
      stall_draw = ((rsp_total % 256) < 64) ? 0 : $urandom_range(0, 4);
      rsp_ready <= (stall_draw == 0);
      stall_left <= (stall_draw == 0) ? 0 : stall_draw - 1;
    end else if (stall_left != 0) begin
      rsp_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // long receiver stall so the block backs up into the request side
  initial begin
    wait (rsp_total >= 400);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    req_fire <= !rst && req_valid && req_ready;
    rsp_fire <= !rst && rsp_valid && rsp_ready;
    if (!rst && req_valid && req_ready) begin
      search_step(track_state, {req_type, presence, id_bit, cmp_bit, taken_dir}, predicted);
      expected_rsps.push_back(predicted);
    end
    if (!rst && rsp_valid && rsp_ready) begin
      rsp_total <= rsp_total + 1;
      if (expected_rsps.size() == 0) begin
        if (mismatches < 10) begin
          $display("response %0d with no request pending: kind %0d code %h",
                   rsp_total, kind, rom_code);
        end
        mismatches++;
      end else begin
        want = expected_rsps.pop_front();
        if (kind !== want.kind || direction !== want.direction || rom_code !== want.rom_code
            || family_discrepancy !== want.family || last_device !== want.last) begin
          if (mismatches < 10) begin
            $display("response %0d expected kind %0d dir %0b code %h fam %0d last %0b",
                     rsp_total, want.kind, want.direction, want.rom_code, want.family,
                     want.last);
            $display("response %0d got      kind %0d dir %0b code %h fam %0d last %0b",
                     rsp_total, kind, direction, rom_code, family_discrepancy, last_device);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("onewire_rom_search: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

[files.f]
+incdir+src
src/ors_pkg.sv
src/ors_in_reg.sv
src/ors_engine.sv
src/ors_out_reg.sv
src/onewire_rom_search.sv
sim/onewire_rom_search_test.sv
